FILE: hw/rtl/f16c_pkg.sv
// Shared types and modulo-255 arithmetic for the Fletcher-16 check engine.
// No dependencies; imported by every module of the block.
package f16c_pkg;

   localparam int ByteWidth = 8;
   localparam logic [ByteWidth-1:0] ModBase = 8'd255;

   // Controls the sum registers for one byte step.
   typedef struct packed {
      logic step;      // a word leaves the input register this cycle
      logic first;     // restart the sums before adding the byte
      logic use_seed;  // restart from seeds instead of zero
   } acc_ctrl_type;

   // (a + b) mod 255 for a, b in 0..255; the sum tops out at 510.
   function automatic logic [ByteWidth-1:0] add_mod255(input logic [ByteWidth-1:0] a,
                                                       input logic [ByteWidth-1:0] b);
      logic [ByteWidth:0] s;
      logic [ByteWidth:0] base;
      logic [ByteWidth:0] r;
      begin
         base = {1'b0, ModBase};
         s = {1'b0, a} + {1'b0, b};
         if (s >= (base << 1)) begin
            r = '0;
         end else if (s >= base) begin
            r = s - base;
         end else begin
            r = s;
         end
         return r[ByteWidth-1:0];
      end
   endfunction

endpackage

FILE: hw/rtl/f16c_accum.sv
// Running Fletcher-16 sums: restart/seed logic and the two chained mod-255 adders.
// Depends on f16c_pkg.
module f16c_accum
   import f16c_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  acc_ctrl_type         ctrl,
   input  logic [ByteWidth-1:0] data_byte,
   input  logic [ByteWidth-1:0] seed_low,
   input  logic [ByteWidth-1:0] seed_high,
   output logic [ByteWidth-1:0] sum_low,
   output logic [ByteWidth-1:0] sum_high
);

   logic [ByteWidth-1:0] running_low_ff;
   logic [ByteWidth-1:0] running_high_ff;
   logic [ByteWidth-1:0] running_low_in;
   logic [ByteWidth-1:0] running_high_in;
   logic [ByteWidth-1:0] base_low;
   logic [ByteWidth-1:0] base_high;

   always_comb begin
      base_low  = running_low_ff;
      base_high = running_high_ff;
      if (ctrl.first) begin
         base_low  = ctrl.use_seed ? seed_low  : '0;
         base_high = ctrl.use_seed ? seed_high : '0;
      end
      sum_low  = add_mod255(base_low, data_byte);
      sum_high = add_mod255(sum_low, base_high);
      running_low_in  = ctrl.step ? sum_low  : running_low_ff;
      running_high_in = ctrl.step ? sum_high : running_high_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_low_ff  <= '0;
         running_high_ff <= '0;
      end else begin
         running_low_ff  <= running_low_in;
         running_high_ff <= running_high_in;
      end
   end

endmodule

FILE: hw/rtl/f16c_result.sv
// Result stage: check-byte computation and the output word register.
// Depends on f16c_pkg.
module f16c_result
   import f16c_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [ByteWidth-1:0] sum_low,
   input  logic [ByteWidth-1:0] sum_high,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ByteWidth-1:0] rsp_sum_low,
   output logic [ByteWidth-1:0] rsp_sum_high,
   output logic [ByteWidth-1:0] rsp_check_low,
   output logic [ByteWidth-1:0] rsp_check_high,
   output logic                 rsp_valid_res
);

   logic                 vld_ff;
   logic                 vld_in;
   logic [ByteWidth-1:0] sum_low_ff;
   logic [ByteWidth-1:0] sum_high_ff;
   logic [ByteWidth-1:0] check_low_ff;
   logic [ByteWidth-1:0] check_high_ff;
   logic                 good_ff;
   logic [ByteWidth-1:0] check_low_in;
   logic [ByteWidth-1:0] check_high_in;

   // c0 = 255 - (lo + hi) mod 255, c1 = 255 - (c0 + lo) mod 255
   always_comb begin
      check_low_in  = ModBase - add_mod255(sum_low, sum_high);
      check_high_in = ModBase - add_mod255(check_low_in, sum_low);
   end

   assign free   = !vld_ff || !rsp_stall;
   assign vld_in = load ? 1'b1 : (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_low_ff    <= sum_low;
         sum_high_ff   <= sum_high;
         check_low_ff  <= check_low_in;
         check_high_ff <= check_high_in;
         good_ff       <= (sum_low == '0) && (sum_high == '0);
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_sum_low    = sum_low_ff;
   assign rsp_sum_high   = sum_high_ff;
   assign rsp_check_low  = check_low_ff;
   assign rsp_check_high = check_high_ff;
   assign rsp_valid_res  = good_ff;

`ifndef NO_ASSERTIONS
   a_sums_reduced: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (sum_low_ff != ModBase) && (sum_high_ff != ModBase))
      else $error("result sum not reduced mod 255");

   a_checks_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (check_low_ff != '0) && (check_high_ff != '0))
      else $error("check byte out of range");

   a_good_checks: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && good_ff) |-> (check_low_ff == ModBase) && (check_high_ff == ModBase))
      else $error("zero sums must give all-ones check bytes");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && rsp_stall) |-> !load)
      else $error("stalled result overwritten");
`endif

endmodule

FILE: hw/rtl/fletcher16_check_engine.sv
// Top level of the Fletcher-16 check engine: input word register and stage control.
// Depends on f16c_pkg, f16c_accum and f16c_result.
//
// Usage:
//   The req_ channel takes one packet byte per word, with first/use_seed/seed
//   fields to restart the sums and last to mark the end of a packet or segment.
//   A word is taken on a rising edge with req_valid high and req_stall low.
//   The rsp_ channel gives one word per byte that carries last: both sums, the
//   two check bytes to append, and rsp_valid_res (both sums zero).
//   Path: a last byte passes the input register, then the output register,
//   which shows its result.
//   Throughput: one byte per cycle while req_stall is low; the sum update runs
//   through two chained mod-255 adders, so bytes follow back to back.
//   Stall: a stalled result is held in the output register; the input register
//   keeps taking bytes without last, and only a last byte waits for the output
//   register to free, which raises req_stall.
//   Reset (synchronous, active high) empties both registers and clears the
//   running sums to zero.
module fletcher16_check_engine
   import f16c_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteWidth-1:0] req_data_byte,
   input  logic                 req_first,
   input  logic                 req_use_seed,
   input  logic [ByteWidth-1:0] req_seed_low,
   input  logic [ByteWidth-1:0] req_seed_high,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ByteWidth-1:0] rsp_sum_low,
   output logic [ByteWidth-1:0] rsp_sum_high,
   output logic [ByteWidth-1:0] rsp_check_low,
   output logic [ByteWidth-1:0] rsp_check_high,
   output logic                 rsp_valid_res
);

   logic                 in_vld_ff;
   logic                 in_vld_in;
   logic [ByteWidth-1:0] data_ff;
   logic                 first_ff;
   logic                 use_seed_ff;
   logic [ByteWidth-1:0] seed_low_ff;
   logic [ByteWidth-1:0] seed_high_ff;
   logic                 last_ff;

   logic                 accept;
   logic                 advance;
   logic                 out_free;
   acc_ctrl_type         ctrl;
   logic [ByteWidth-1:0] sum_low;
   logic [ByteWidth-1:0] sum_high;

   // only a last byte needs room in the output register
   assign advance   = in_vld_ff && (!last_ff || out_free);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff      <= req_data_byte;
         first_ff     <= req_first;
         use_seed_ff  <= req_use_seed;
         seed_low_ff  <= req_seed_low;
         seed_high_ff <= req_seed_high;
         last_ff      <= req_last;
      end
   end

   always_comb begin
      ctrl.step     = advance;
      ctrl.first    = first_ff;
      ctrl.use_seed = use_seed_ff;
   end

   f16c_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .data_byte (data_ff),
      .seed_low  (seed_low_ff),
      .seed_high (seed_high_ff),
      .sum_low   (sum_low),
      .sum_high  (sum_high)
   );

   f16c_result u_result (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && last_ff),
      .sum_low        (sum_low),
      .sum_high       (sum_high),
      .free           (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sum_low    (rsp_sum_low),
      .rsp_sum_high   (rsp_sum_high),
      .rsp_check_low  (rsp_check_low),
      .rsp_check_high (rsp_check_high),
      .rsp_valid_res  (rsp_valid_res)
   );

endmodule
